// File: src/gcd_pkg.sv
package gcd_pkg;

	// binary gcd step stages per item: 2*w - 1 always suffice for w-bit operands,
	// one spare stage keeps the chain at 2*w
	function automatic int gcd_steps(input int w);
		gcd_steps = 2 * w;
	endfunction

endpackage

// File: src/gcd_stage.sv
// one binary gcd step: strip common twos, halve a lone even operand, or reduce the larger odd operand
module gcd_stage import gcd_pkg::*; #(
	parameter int DATA_WIDTH = 31,
	parameter int SHIFT_WIDTH = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [DATA_WIDTH-1:0]  in_a,
	input  logic [DATA_WIDTH-1:0]  in_b,
	input  logic [SHIFT_WIDTH-1:0] in_k,
	input  logic                   in_bad,
	output logic                   out_valid,
	output logic [DATA_WIDTH-1:0]  out_a,
	output logic [DATA_WIDTH-1:0]  out_b,
	output logic [SHIFT_WIDTH-1:0] out_k,
	output logic                   out_bad
);

	logic [DATA_WIDTH-1:0]  a_n, b_n, diff;
	logic [SHIFT_WIDTH-1:0] k_n;

	// once b is zero the item is done and the step passes it through unchanged
	always_comb begin
		a_n  = in_a;
		b_n  = in_b;
		k_n  = in_k;
		diff = (in_a > in_b) ? in_a - in_b : in_b - in_a;
		if (in_b != '0) begin
			if (!in_a[0] && !in_b[0]) begin
				a_n = in_a >> 1;
				b_n = in_b >> 1;
				k_n = in_k + 1'b1;
			end else if (!in_a[0]) begin
				a_n = in_a >> 1;
			end else if (!in_b[0]) begin
				b_n = in_b >> 1;
			end else begin
				a_n = (in_a < in_b) ? in_a : in_b;
				b_n = diff >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_a   <= a_n;
			out_b   <= b_n;
			out_k   <= k_n;
			out_bad <= in_bad;
		end
	end

endmodule

// File: src/gcd_unit.sv
// gcd_unit: binary gcd of two unsigned operands, fully pipelined
// data path: entry register, the 2*DATA_WIDTH step stages, then the output register
// throughput: one transfer per cycle while the output is not stalled
// a stall on the output freezes the whole pipe, nothing is lost or repeated
// reset: arst_n clears all valid bits asynchronously, payload registers are not reset
module gcd_unit import gcd_pkg::*; #(
	parameter int DATA_WIDTH = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [DATA_WIDTH-1:0] first_value, [2*DATA_WIDTH-1:DATA_WIDTH] second_value, zero pad
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [DATA_WIDTH-1:0] gcd_result, zero pad
	output logic [((DATA_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
	// [0] invalid
	output logic                  m_axis_tuser
);

	localparam int Steps   = gcd_steps(DATA_WIDTH);
	localparam int KW      = $clog2(DATA_WIDTH + 1);
	localparam int OutBits = ((DATA_WIDTH + 7) / 8) * 8;

	// the pipe advances whenever the output register is free or being drained
	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic [DATA_WIDTH-1:0] first_value, second_value;
	assign first_value  = s_axis_tdata[DATA_WIDTH-1:0];
	assign second_value = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

	// stage chain, index 0 is the entry register
	logic                  v_s  [Steps+1];
	logic [DATA_WIDTH-1:0] a_s  [Steps+1];
	logic [DATA_WIDTH-1:0] b_s  [Steps+1];
	logic [KW-1:0]         k_s  [Steps+1];
	logic                  bad_s[Steps+1];

	// entry register: flag a zero operand, which the steps leave alone via b = 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_s[0] <= (first_value == '0) || (second_value == '0);
			a_s[0]   <= first_value;
			b_s[0]   <= (first_value == '0) ? '0 : second_value;
			k_s[0]   <= '0;
		end
	end

	for (genvar i = 0; i < Steps; i++) begin : g_step
		gcd_stage #(.DATA_WIDTH(DATA_WIDTH), .SHIFT_WIDTH(KW)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_s[i]),
			.in_a      (a_s[i]),
			.in_b      (b_s[i]),
			.in_k      (k_s[i]),
			.in_bad    (bad_s[i]),
			.out_valid (v_s[i+1]),
			.out_a     (a_s[i+1]),
			.out_b     (b_s[i+1]),
			.out_k     (k_s[i+1]),
			.out_bad   (bad_s[i+1])
		);
	end

	// output register: restore the common power of two, or give zero for a flagged zero operand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			m_axis_tvalid <= v_s[Steps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tuser <= bad_s[Steps];
			m_axis_tdata <= bad_s[Steps] ? '0
				: OutBits'(a_s[Steps] << k_s[Steps]);
		end
	end

endmodule
